### rtl/ssd_pkg.sv
// Shared types, widths and codes for the stream silence detector.
// No dependencies; every other file in rtl/ imports this package.
package ssd_pkg;

  // Default size of the silence window (frames)
  localparam int WINDOW_BITS_DEF = 64;

  // Field widths
  localparam int OP_W       = 2;
  localparam int ALT_W      = 8;
  localparam int TICK_W     = 32;
  localparam int CMD_W      = 2;
  localparam int FRAMES_W   = 7;
  localparam int THRESH_W   = 7;
  localparam int HOLD_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(8);
  localparam logic [HOLD_W-1:0]   HOLD_RESET   = HOLD_W'(100);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HOLD      = CFG_IDX_W'(1);

  // Event kinds
  typedef enum logic [OP_W-1:0] {
    OP_FRAME  = 2'd0,
    OP_PACKET = 2'd1,
    OP_ALT    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Codec commands
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE  = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_START = 2'd2
  } cmd_t;

  // One input beat
  typedef struct packed {
    op_t               op;
    logic [ALT_W-1:0]  alt_value;
    logic [TICK_W-1:0] now_tick;
  } event_t;

  // One result beat
  typedef struct packed {
    cmd_t                codec_cmd;
    logic [FRAMES_W-1:0] silent_frames;
    logic                codec_on;
  } result_t;

  // Configuration write strobe
  typedef struct packed {
    logic                  wr;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

### rtl/ssd_in_reg.sv
// Input register stage: captures one event beat and holds it until the
// engine consumes it. Depends on ssd_pkg.
module ssd_in_reg
  import ssd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  event_t in_event,
  input  logic   advance,
  output logic   ev_valid,
  output event_t ev
);

  // Stall only when a held beat cannot move on this cycle
  assign in_stall = ev_valid && !advance;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!in_stall) begin
      ev_valid <= in_valid;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      ev <= in_event;
    end
  end

endmodule

### rtl/ssd_engine.sv
// Silence detection engine: config registers, detector state and the
// combinational next-state / command logic. Depends on ssd_pkg.
module ssd_engine
  import ssd_pkg::*;
#(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_wr_t cfg,
  input  logic    fire,
  input  event_t  ev,
  output result_t res
);

  localparam int CNT_W = $clog2(WINDOW_BITS + 1);

  // Configuration
  logic [THRESH_W-1:0] silence_threshold;
  logic [HOLD_W-1:0]   hold_time;

  // Detector state; count tracks the ones in window
  logic [WINDOW_BITS-1:0] window, window_next;
  logic [CNT_W-1:0]       count, count_next;
  logic                   no_write, no_write_next;
  logic [TICK_W-1:0]      stamp, stamp_next;
  logic [ALT_W-1:0]       stream_alt, stream_alt_next;
  logic                   running, running_next;
  cmd_t                   cmd;
  logic [TICK_W-1:0]      elapsed;

  // Config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      silence_threshold <= THRESH_RESET;
      hold_time         <= HOLD_RESET;
    end else if (cfg.wr) begin
      if (cfg.index == REG_THRESHOLD) begin
        silence_threshold <= cfg.data[THRESH_W-1:0];
      end else if (cfg.index == REG_HOLD) begin
        hold_time <= cfg.data[HOLD_W-1:0];
      end
    end
  end

  // Next state and command for the beat at the head of the pipe
  always_comb begin
    window_next     = window;
    count_next      = count;
    no_write_next   = no_write;
    stamp_next      = stamp;
    stream_alt_next = stream_alt;
    running_next    = running;
    cmd             = CMD_NONE;
    elapsed         = '0;
    unique case (ev.op)
      OP_FRAME: begin
        if (stream_alt != '0) begin
          // shift in last frame's silence bit, keep count in step
          window_next   = {window[WINDOW_BITS-2:0], no_write};
          count_next    = count + CNT_W'(no_write) - CNT_W'(window[WINDOW_BITS-1]);
          no_write_next = 1'b1;
          if (FRAMES_W'(count_next) >= silence_threshold) begin
            if (running) begin
              running_next = 1'b0;
              cmd          = CMD_STOP;
            end
            stamp_next = ev.now_tick;
          end
          elapsed = ev.now_tick - stamp_next;
          if (!running_next && count_next == '0 && elapsed > hold_time) begin
            running_next = 1'b1;
            cmd          = CMD_START;
          end
        end
      end
      OP_PACKET: begin
        no_write_next = 1'b0;
      end
      OP_ALT: begin
        stream_alt_next = ev.alt_value;
        if (ev.alt_value == '0) begin
          running_next = 1'b0;
          cmd          = CMD_STOP;
        end else begin
          running_next  = 1'b1;
          cmd           = CMD_START;
          no_write_next = 1'b0;
          window_next   = '0;
          count_next    = '0;
        end
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // State update on each consumed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      count      <= '0;
      no_write   <= 1'b0;
      stamp      <= '0;
      stream_alt <= '0;
      running    <= 1'b0;
    end else if (fire) begin
      window     <= window_next;
      count      <= count_next;
      no_write   <= no_write_next;
      stamp      <= stamp_next;
      stream_alt <= stream_alt_next;
      running    <= running_next;
    end
  end

  // Result reflects state after the event
  assign res.codec_cmd     = cmd;
  assign res.silent_frames = FRAMES_W'(count_next);
  assign res.codec_on      = running_next;

endmodule

### rtl/ssd_out_reg.sv
// Result register: holds one result beat until the sink takes it.
// Depends on ssd_pkg.
module ssd_out_reg
  import ssd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  input  logic    out_stall,
  output logic    out_valid,
  output logic    advance,
  output result_t res_out
);

  // Room for a new beat when empty or the held one leaves now
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && advance) begin
      res_out <= res_in;
    end
  end

endmodule

### rtl/stream_silence_detector.sv
// Stream silence detector top level: input register, engine, result register.
// A beat goes from the input register through the engine into the result register.
// Throughput: one event per cycle (state update loop) while out_stall is low.
// Reset (synchronous, rst high): window, stamp, alt setting cleared, codec off,
// threshold 8, hold time 100; config port always ready. Depends on ssd_pkg.
module stream_silence_detector
  import ssd_pkg::*;
#(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // event stream
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       op,
  input  logic [ALT_W-1:0]      alt_value,
  input  logic [TICK_W-1:0]     now_tick,
  // result stream
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CMD_W-1:0]      codec_cmd,
  output logic [FRAMES_W-1:0]   silent_frames,
  output logic                  codec_on,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  event_t  in_event, ev;
  logic    ev_valid, advance, fire;
  result_t res, res_q;
  cfg_wr_t cfg;

  assign in_event.op        = op_t'(op);
  assign in_event.alt_value = alt_value;
  assign in_event.now_tick  = now_tick;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Head beat is processed when the result register has room
  assign fire = ev_valid && advance;

  ssd_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_event (in_event),
    .advance  (advance),
    .ev_valid (ev_valid),
    .ev       (ev)
  );

  ssd_engine #(.WINDOW_BITS(WINDOW_BITS)) u_engine (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .ev   (ev),
    .res  (res)
  );

  ssd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (ev_valid),
    .res_in    (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .advance   (advance),
    .res_out   (res_q)
  );

  assign codec_cmd     = res_q.codec_cmd;
  assign silent_frames = res_q.silent_frames;
  assign codec_on      = res_q.codec_on;

endmodule

### rtl/ssd_checker.sv
// Port-level assertions for stream_silence_detector, attached by bind.
// Depends on ssd_pkg.
module ssd_port_checker
  import ssd_pkg::*;
#(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CMD_W-1:0]    codec_cmd,
  input logic [FRAMES_W-1:0] silent_frames,
  input logic                codec_on
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(codec_cmd) &&
      $stable(silent_frames) && $stable(codec_on))
    else $error("stalled result changed");

  // Stop leaves codec off, start leaves it on
  a_cmd_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (codec_cmd != CMD_STOP || !codec_on) &&
      (codec_cmd != CMD_START || codec_on))
    else $error("codec command disagrees with codec_on");

  // Only defined command codes
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> codec_cmd == CMD_NONE || codec_cmd == CMD_STOP ||
      codec_cmd == CMD_START)
    else $error("undefined codec command");

  // Silent frame count bounded by window size
  a_frames: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> silent_frames <= FRAMES_W'(WINDOW_BITS))
    else $error("silent frame count exceeds window");

endmodule

bind stream_silence_detector ssd_port_checker #(.WINDOW_BITS(WINDOW_BITS)) u_ssd_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .codec_cmd     (codec_cmd),
  .silent_frames (silent_frames),
  .codec_on      (codec_on)
);

### dv/ssd_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the stream silence detector: tracks the silence window, codec
// state and register settings from the beats it sees, and checks every result.
// Depends on ssd_pkg.
module ssd_checker
  import ssd_pkg::*;
#(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [OP_W-1:0]       op,
  input  logic [ALT_W-1:0]      alt_value,
  input  logic [TICK_W-1:0]     now_tick,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [CMD_W-1:0]      codec_cmd,
  input  logic [FRAMES_W-1:0]   silent_frames,
  input  logic                  codec_on,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding
);

  // Register copies
  logic [THRESH_W-1:0]    threshold;
  logic [HOLD_W-1:0]      hold;

  // Detector state copy
  logic [WINDOW_BITS-1:0] window;
  logic                   no_packet;
  logic [TICK_W-1:0]      stamp;
  logic [ALT_W-1:0]       alt_setting;
  logic                   codec_run;

  // Codec reports still owed by the block, oldest first
  result_t                due_reports[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Applies one event to the state copy and returns the report it should cause
  task automatic track_silence(input op_t kind, input logic [ALT_W-1:0] alt,
                               input logic [TICK_W-1:0] tick, output result_t res);
    cmd_t              cmd;
    int unsigned       ones;
    logic [TICK_W-1:0] elapsed;
    cmd = CMD_NONE;
    case (kind)
      OP_FRAME: begin
        // frames only count while the stream is open
        if (alt_setting != '0) begin
          window    = {window[WINDOW_BITS-2:0], no_packet};
          no_packet = 1'b1;
          ones      = $countones(window);
          if (ones >= threshold) begin
            if (codec_run) begin
              codec_run = 1'b0;
              cmd       = CMD_STOP;
            end
            stamp = tick;
          end
          elapsed = tick - stamp;
          if (!codec_run && ones == 0 && elapsed > hold) begin
            codec_run = 1'b1;
            cmd       = CMD_START;
          end
        end
      end
      OP_PACKET: no_packet = 1'b0;
      OP_ALT: begin
        alt_setting = alt;
        if (alt == '0) begin
          codec_run = 1'b0;
          cmd       = CMD_STOP;
        end else begin
          codec_run = 1'b1;
          cmd       = CMD_START;
          no_packet = 1'b0;
          window    = '0;
        end
      end
      default: ;
    endcase
    res.codec_cmd     = cmd;
    res.silent_frames = FRAMES_W'($countones(window));
    res.codec_on      = codec_run;
  endtask

  always @(posedge clk) begin
    result_t want;
    result_t res;
    if (rst) begin
      threshold   = THRESH_RESET;
      hold        = HOLD_RESET;
      window      = '0;
      no_packet   = 1'b0;
      stamp       = '0;
      alt_setting = '0;
      codec_run   = 1'b0;
      due_reports.delete();
    end else begin
      // result beat: compare with the oldest report owed
      if (out_valid && !out_stall) begin
        if (due_reports.size() == 0) begin
          report_mismatch("result beat with nothing owed, codec_cmd", codec_cmd, 0);
        end else begin
          want = due_reports.pop_front();
          if (codec_cmd !== want.codec_cmd)
            report_mismatch("codec_cmd", codec_cmd, want.codec_cmd);
          if (silent_frames !== want.silent_frames)
            report_mismatch("silent_frames", silent_frames, want.silent_frames);
          if (codec_on !== want.codec_on)
            report_mismatch("codec_on", codec_on, want.codec_on);
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_THRESHOLD)
          threshold = cfg_data[THRESH_W-1:0];
        else if (cfg_index == REG_HOLD)
          hold = cfg_data[HOLD_W-1:0];
      end
      // event beat
      if (in_valid && !in_stall) begin
        track_silence(op_t'(op), alt_value, now_tick, res);
        due_reports.push_back(res);
      end
    end
    outstanding <= due_reports.size();
  end

endmodule

### dv/tb_stream_silence_detector.sv
`timescale 1ns / 1ps
// Top of the stream silence detector testbench: clock, reset, event and
// register stimulus, result stall pattern and verdict. Depends on ssd_pkg,
// ssd_checker and the detector RTL.
module tb_stream_silence_detector;
  import ssd_pkg::*;

  // Indexes past the last register, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);
  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_OFF_LEN  = 80;
  localparam int PHASE_ITEMS   = 110;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       op = '0;
  logic [ALT_W-1:0]      alt_value = '0;
  logic [TICK_W-1:0]     now_tick = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CMD_W-1:0]      codec_cmd;
  logic [FRAMES_W-1:0]   silent_frames;
  logic                  codec_on;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int                    fail_count;
  int                    outstanding;
  int                    tx_gap_pct = 0;
  int                    rx_stall_pct = 0;
  logic                  hold_off_req = 1'b0;
  logic                  hold_off_done = 1'b0;
  int                    hold_off_left = 0;
  int                    quiet_cycles = 0;
  logic [TICK_W-1:0]     tick_now;

  always #6 clk = ~clk;

  stream_silence_detector dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .alt_value(alt_value), .now_tick(now_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .codec_cmd(codec_cmd), .silent_frames(silent_frames), .codec_on(codec_on),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ssd_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .alt_value(alt_value), .now_tick(now_tick),
    .out_valid(out_valid), .out_stall(out_stall),
    .codec_cmd(codec_cmd), .silent_frames(silent_frames), .codec_on(codec_on),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  // Result side: random stalls, plus one long hold-off so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off_left > 0) begin
      out_stall     <= 1'b1;
      hold_off_left <= hold_off_left - 1;
    end else if (hold_off_req && !hold_off_done) begin
      out_stall     <= 1'b1;
      hold_off_left <= HOLD_OFF_LEN;
      hold_off_done <= 1'b1;
    end else begin
      out_stall <= (rx_stall_pct > 0) && ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Watchdog: too long with no beat on any channel ends the run
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One event beat, with random gaps ahead of it in sender-idle phases
  task automatic send_event(input op_t kind, input logic [ALT_W-1:0] alt,
                            input logic [TICK_W-1:0] tick);
    while (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    op        <= kind;
    alt_value <= alt;
    now_tick  <= tick;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and let every owed result drain before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Threshold goes out with random junk above its 7 bits
  task automatic set_config(input logic [THRESH_W-1:0] thresh,
                            input logic [HOLD_W-1:0] hold);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[THRESH_W-1:0] = thresh;
    write_reg(REG_THRESHOLD, data);
    write_reg(REG_HOLD, hold);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: mostly bursts of frames with a chosen silence rate,
  // some stream open/close and some noise
  task automatic run_random_phase(input int quota);
    int sent;
    int roll;
    int burst;
    int silence_pct;
    sent = 0;
    send_event(OP_ALT, ALT_W'($urandom_range(1, 255)), tick_now);
    sent++;
    while (sent < quota) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        send_event(op_t'($urandom_range(0, 3)), ALT_W'($urandom), $urandom);
        sent++;
      end else if (roll < 18) begin
        // close the stream for a few frames, then reopen
        send_event(OP_ALT, '0, tick_now);
        repeat ($urandom_range(0, 3)) begin
          tick_now += $urandom_range(1, 6);
          send_event(OP_FRAME, ALT_W'($urandom), tick_now);
          sent++;
        end
        send_event(OP_ALT, ALT_W'($urandom_range(1, 255)), tick_now);
        sent += 2;
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          // long clean run: long enough to empty the window
          burst       = $urandom_range(64, 72);
          silence_pct = 0;
        end else begin
          burst = $urandom_range(4, 24);
          case ($urandom_range(0, 3))
            0: silence_pct = 0;
            1: silence_pct = 5;
            2: silence_pct = 40;
            default: silence_pct = 100;
          endcase
        end
        repeat (burst) begin
          if ($urandom_range(0, 99) >= silence_pct) begin
            send_event(OP_PACKET, ALT_W'($urandom), tick_now);
            sent++;
          end
          tick_now += $urandom_range(1, 6);
          send_event(OP_FRAME, ALT_W'($urandom), tick_now);
          sent++;
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: inactive stream, ignored op, repeated settings, stamping
    set_config(THRESH_W'(1), HOLD_RESET);
    write_reg(REG_SPARE_LO, $urandom);
    write_reg(REG_SPARE_HI, '1);
    cfg_valid <= 1'b0;
    send_event(OP_FRAME, '0, '0);
    send_event(OP_NONE, '1, '1);
    send_event(OP_ALT, '0, 32'd1);
    send_event(OP_ALT, '0, 32'd2);
    send_event(OP_ALT, '1, 32'd3);
    send_event(OP_ALT, '1, 32'd4);
    send_event(OP_FRAME, '0, 32'd10);
    send_event(OP_FRAME, '0, 32'd20);
    // threshold reached again with the codec already stopped
    send_event(OP_FRAME, '0, 32'd21);
    send_event(OP_PACKET, '1, 32'd21);
    send_event(OP_ALT, ALT_W'(1), 32'd22);
    wait_idle();

    // Zero threshold stops on a clean frame; stamp just below the wrap
    set_config('0, HOLD_W'(5));
    send_event(OP_PACKET, '0, 32'hFFFF_FFFC);
    send_event(OP_FRAME, '0, 32'hFFFF_FFFD);
    wait_idle();

    // Threshold past the window: hold boundary across the wrap, then restart
    set_config('1, HOLD_W'(5));
    send_event(OP_PACKET, '0, 32'd1);
    send_event(OP_FRAME, '0, 32'd2);
    send_event(OP_PACKET, '0, 32'd2);
    send_event(OP_FRAME, '0, 32'd3);
    send_event(OP_FRAME, '0, 32'd4);
    send_event(OP_FRAME, '0, 32'd5);
    send_event(OP_FRAME, '0, 32'd6);
    send_event(OP_NONE, '0, 32'd6);
    send_event(OP_ALT, '0, 32'd7);
    send_event(OP_FRAME, '0, 32'd8);
    wait_idle();

    // Random phases; the first one also carries the long hold-off
    set_config(THRESH_RESET, HOLD_RESET);
    tick_now     = $urandom;
    hold_off_req = 1'b1;
    run_random_phase(PHASE_ITEMS);
    wait_idle();

    set_config(THRESH_W'(1), '0);
    tick_now   = 32'hFFFF_FF80;
    tx_gap_pct = 50;
    run_random_phase(PHASE_ITEMS);
    wait_idle();

    set_config(THRESH_W'(64), '1);
    tx_gap_pct   = 0;
    rx_stall_pct = 50;
    run_random_phase(PHASE_ITEMS);
    wait_idle();

    set_config(THRESH_W'($urandom_range(2, 20)), HOLD_W'($urandom_range(0, 400)));
    tx_gap_pct   = 24;
    rx_stall_pct = 24;
    run_random_phase(PHASE_ITEMS);
    wait_idle();

    // Idle on to catch any stray result beat before the verdict
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### files.f
rtl/ssd_pkg.sv
rtl/ssd_in_reg.sv
rtl/ssd_engine.sv
rtl/ssd_out_reg.sv
rtl/stream_silence_detector.sv
rtl/ssd_checker.sv
dv/ssd_checker.sv
dv/tb_stream_silence_detector.sv
